// File: rtl/core/lpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg: shared types for the length-prefix deframer
// Slot table entry, request command codes and the per-request update result.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int PROG_W = 3;
	localparam int LEN_W  = 32;
	localparam int BYTE_W = 8;
	localparam int SLOT_W = 6;

	typedef enum logic {
		CMD_DATA  = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [PROG_W-1:0] progress;
		logic [LEN_W-1:0]  remaining;
		logic              started;
	} slot_entry_t;

	typedef struct packed {
		logic              write;
		slot_entry_t       entry;
		logic              res_valid;
		logic [BYTE_W-1:0] res_byte;
		logic              res_first;
		logic              res_last;
		logic              res_empty;
	} upd_t;

endpackage

// File: rtl/core/lpd_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_slot_mem: per-slot state memory
// One write port, one registered read port; a write to the entry being read
// at the same edge is forwarded to the read data.
// ----------------------------------------------------------------------------
module lpd_slot_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  lpd_pkg::slot_entry_t wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output lpd_pkg::slot_entry_t rd_data
);
	import lpd_pkg::*;

	slot_entry_t mem_q [DEPTH];
	slot_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read-before-write memory; bypass the write that lands on the same entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/lpd_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_update: slot state update
// Computes the new slot entry and the result for one data or clear request.
// ----------------------------------------------------------------------------
module lpd_update #(
	parameter int HEAD_BYTES = 4
) (
	input  logic                      in_range,
	input  lpd_pkg::cmd_t             cmd,
	input  logic [lpd_pkg::BYTE_W-1:0] data_in,
	input  lpd_pkg::slot_entry_t      cur,
	output lpd_pkg::upd_t             upd
);
	import lpd_pkg::*;

	localparam logic [PROG_W-1:0] HEAD_CNT = PROG_W'(HEAD_BYTES);

	logic [PROG_W-1:0] prog_inc;
	logic [LEN_W-1:0]  len_shift;
	logic [LEN_W-1:0]  len_dec;

	assign prog_inc  = cur.progress + PROG_W'(1);
	assign len_shift = {cur.remaining[LEN_W-BYTE_W-1:0], data_in};
	assign len_dec   = cur.remaining - LEN_W'(1);

	always_comb begin
		upd           = '0;
		upd.res_byte  = data_in;
		if (!in_range) begin
			upd.write = 1'b0;
		end else if (cmd == CMD_CLEAR) begin
			upd.write = 1'b1;
		end else if (cur.progress < HEAD_CNT) begin
			// Header byte: shift into the length.
			upd.write           = 1'b1;
			upd.entry.progress  = prog_inc;
			upd.entry.remaining = len_shift;
			upd.entry.started   = 1'b0;
			if ((prog_inc >= HEAD_CNT) && (len_shift == '0)) begin
				upd.entry     = '0;
				upd.res_valid = 1'b1;
				upd.res_byte  = '0;
				upd.res_empty = 1'b1;
			end
		end else begin
			// Payload byte.
			upd.write           = 1'b1;
			upd.res_valid       = 1'b1;
			upd.res_first       = !cur.started;
			upd.res_last        = (len_dec == '0);
			upd.entry.progress  = cur.progress;
			upd.entry.remaining = len_dec;
			upd.entry.started   = 1'b1;
			if (len_dec == '0) begin
				upd.entry = '0;
			end
		end
	end

endmodule

// File: rtl/core/length_prefix_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefix_deframer: multi-connection length-prefixed message splitter
// Each slot's byte stream carries a big-endian length header followed by
// that many payload bytes; payload bytes leave with first/last marks.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  -------  --------------------  ---------------------------------------------
//  in       in_valid / in_ready   command, conn_slot, data_byte
//  out      out_valid / out_ready out_slot, payload_byte, first_of_message,
//                                 last_of_message, empty_message
//
// One request per clock sustained while the output is not stalled; the slot entry
// is read into the memory's read register when the request is accepted, and
// the result then lands in the output register, from which it can leave.
// The slot state lives in one synchronous memory: read at acceptance, updated
// and written back when the request leaves the update stage. A request to
// the slot just updated takes the write data through the memory's bypass, so
// back-to-back requests to one slot run at full rate.
// After reset a clearing pass writes every slot to zero with in_ready low.
// A stall on out_ready holds the update stage, and after the clearing pass
// the input stalls only when that stage holds a result that cannot move.
// ----------------------------------------------------------------------------
module length_prefix_deframer #(
	parameter int NUM_SLOTS  = 64,
	parameter int HEAD_BYTES = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [lpd_pkg::SLOT_W-1:0]  conn_slot,
	input  logic [lpd_pkg::BYTE_W-1:0]  data_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lpd_pkg::SLOT_W-1:0]  out_slot,
	output logic [lpd_pkg::BYTE_W-1:0]  payload_byte,
	output logic                        first_of_message,
	output logic                        last_of_message,
	output logic                        empty_message
);
	import lpd_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CMP_W = 13;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_idx_q;

	logic [CMP_W-1:0]   slot_ext;
	logic               in_accept;

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               in_range_s1;

	slot_entry_t        rd_entry;
	slot_entry_t        wr_entry;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	upd_t               upd;
	logic               s1_advance;
	logic               out_load;

	logic               out_valid_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_first_q;
	logic               out_last_q;
	logic               out_empty_q;

	assign slot_ext  = CMP_W'(conn_slot);
	assign in_accept = in_valid && in_ready;

	// Advance the update stage unless its result is blocked by a full output.
	assign s1_advance = valid_s1 && (!upd.res_valid || !out_valid_q || out_ready);
	assign in_ready   = (state_q == ST_RUN) && (!valid_s1 || s1_advance);
	assign out_load   = s1_advance && upd.res_valid;

	// Clearing pass after reset: sweep every slot to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == LAST_IDX) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Update stage: holds the request while its slot entry is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1      <= cmd_t'(command);
			slot_s1     <= conn_slot;
			idx_s1      <= slot_ext[IDX_W-1:0];
			byte_s1     <= data_byte;
			in_range_s1 <= (slot_ext < CMP_W'(NUM_SLOTS));
		end
	end

	// Write back once per in-range request, when it leaves the update stage.
	assign wr_en    = (state_q == ST_CLEAR) || (s1_advance && upd.write);
	assign wr_addr  = (state_q == ST_CLEAR) ? clr_idx_q : idx_s1;
	assign wr_entry = (state_q == ST_CLEAR) ? slot_entry_t'('0) : upd.entry;

	lpd_slot_mem #(
		.DEPTH  (NUM_SLOTS),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (in_accept),
		.rd_addr (slot_ext[IDX_W-1:0]),
		.rd_data (rd_entry)
	);

	lpd_update #(
		.HEAD_BYTES (HEAD_BYTES)
	) u_upd (
		.in_range (in_range_s1),
		.cmd      (cmd_s1),
		.data_in  (byte_s1),
		.cur      (rd_entry),
		.upd      (upd)
	);

	// Output register: parts the update stage from the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_slot_q  <= slot_s1;
			out_byte_q  <= upd.res_byte;
			out_first_q <= upd.res_first;
			out_last_q  <= upd.res_last;
			out_empty_q <= upd.res_empty;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_slot         = out_slot_q;
	assign payload_byte     = out_byte_q;
	assign first_of_message = out_first_q;
	assign last_of_message  = out_last_q;
	assign empty_message    = out_empty_q;

`ifndef NO_ASSERTIONS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("request accepted during clearing pass");

	a_ready_means_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && valid_s1) |-> s1_advance)
		else $error("request accepted over a held update stage");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr <= LAST_IDX))
		else $error("slot write beyond table");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");
`endif

endmodule
